/* rtl/dscm_pkg.sv */
// Shared types and constants for the digit sum counter.
// Used by dscm_ctrl, dscm_datapath and digit_sum_count_mod.
`default_nettype none

package dscm_pkg;

  localparam int N_W   = 7;
  localparam int S_W   = 10;
  localparam int CNT_W = 30;

  localparam logic [CNT_W-1:0] MODULUS = 30'd1000000007;
  localparam int DIGIT_MAX  = 9;
  localparam int WINDOW_LEN = DIGIT_MAX + 1;

  // source of the value loaded into the output register
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_ONE_ROW,
    RES_WINDOW
  } res_sel_t;

  typedef struct packed {
    logic     latch;     // capture query fields
    logic     row_init;  // start building row 2 from the generated row 1
    logic     issue;     // read one entry of the source row
    logic     load;      // load output register
    res_sel_t sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic trivial;   // result is zero without any row work
    logic single;    // one digit: row 1 only
    logic col_last;  // issuing the target column
    logic row_last;  // row being built is the last one
  } ctrl_status_t;

endpackage

`default_nettype wire

/* rtl/dscm_ctrl.sv */
// Controller state machine for the digit sum counter.
// Depends on dscm_pkg; drives dscm_datapath through command/status structs.
`default_nettype none

module dscm_ctrl
  import dscm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    RUN,
    DRAIN,
    DONE
  } state_t;

  state_t   state;
  res_sel_t sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      sel       <= RES_ZERO;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      // in DONE a taken item is replaced by the new one below
      if (out_valid && out_ready && (state != DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid && in_ready) begin
            in_ready <= 1'b0;
            state    <= CHECK;
          end
        end
        CHECK: begin
          if (status.trivial) begin
            sel   <= RES_ZERO;
            state <= DONE;
          end else if (status.single) begin
            sel   <= RES_ONE_ROW;
            state <= DONE;
          end else begin
            state <= RUN;
          end
        end
        RUN: begin
          if (status.col_last && status.row_last) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          // last entry of the last row is in the window stage this cycle
          sel   <= RES_WINDOW;
          state <= DONE;
        end
        DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            in_ready  <= 1'b1;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd.latch    = (state == IDLE) && in_valid && in_ready;
    cmd.row_init = (state == CHECK) && !status.trivial && !status.single;
    cmd.issue    = (state == RUN);
    cmd.load     = (state == DONE) && (!out_valid || out_ready);
    cmd.sel      = sel;
  end

endmodule

`default_nettype wire

/* rtl/dscm_datapath.sv */
// Datapath for the digit sum counter: query registers, row/column counters,
// two ping-pong row buffers, the ten-wide window stage and the output register.
// Depends on dscm_pkg; controlled by dscm_ctrl.
`default_nettype none

module dscm_datapath
  import dscm_pkg::*;
#(
  parameter int MAX_DIGITS = 100,
  parameter int SUM_LIMIT  = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  ctrl_cmd_t        cmd,
  output ctrl_status_t     status,
  input  logic [N_W-1:0]   num_digits,
  input  logic [S_W-1:0]   target_sum,
  output logic [CNT_W-1:0] count
);

  localparam int AW  = $clog2(SUM_LIMIT);
  localparam int CMP_W = S_W + 1;

  logic [N_W-1:0]   n_q;
  logic [S_W-1:0]   s_q;

  logic [N_W-1:0]   row_cnt;   // index of the source row
  logic [AW-1:0]    col;
  logic             gen;       // source row is row 1, generated on the fly
  logic             bank;      // buffer written by the row being built

  logic [CNT_W-1:0] mem_a [SUM_LIMIT];
  logic [CNT_W-1:0] mem_b [SUM_LIMIT];
  logic [CNT_W-1:0] rd_a;
  logic [CNT_W-1:0] rd_b;

  // read stage
  logic             p1_valid;
  logic             p1_first;
  logic             p1_gen;
  logic             p1_gen_one;
  logic             p1_wbank;
  logic [AW-1:0]    p1_addr;

  logic [CNT_W-1:0] window;
  logic [CNT_W-1:0] sh [WINDOW_LEN];

  logic [CNT_W-1:0] d;
  logic [CNT_W-1:0] w_prev;
  logic [CNT_W-1:0] old;
  logic [31:0]      t;
  logic [31:0]      tp;
  logic [31:0]      tm;
  logic [CNT_W-1:0] w_new;
  logic [CMP_W-1:0] nine_n;
  logic             gen_val;

  // status
  always_comb begin
    nine_n = ({{(CMP_W-N_W){1'b0}}, n_q} << 3) + {{(CMP_W-N_W){1'b0}}, n_q};
    status.trivial = (n_q == '0) || (n_q > N_W'(MAX_DIGITS)) || (s_q == '0) ||
                     ({1'b0, s_q} >= CMP_W'(SUM_LIMIT)) || ({1'b0, s_q} > nine_n);
    status.single  = (n_q == N_W'(1));
    status.col_last = ({{(CMP_W-AW){1'b0}}, col} == {1'b0, s_q});
    status.row_last = (({1'b0, row_cnt} + (N_W+1)'(1)) == {1'b0, n_q});
    gen_val = (col != '0) && (col <= AW'(DIGIT_MAX));
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      n_q <= num_digits;
      s_q <= target_sum;
    end
  end

  // counters and read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt  <= '0;
      col      <= '0;
      gen      <= 1'b0;
      bank     <= 1'b0;
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= cmd.issue;
      if (cmd.row_init) begin
        row_cnt <= N_W'(1);
        col     <= '0;
        gen     <= 1'b1;
        bank    <= 1'b0;
      end else if (cmd.issue) begin
        if (status.col_last) begin
          col     <= '0;
          row_cnt <= row_cnt + N_W'(1);
          gen     <= 1'b0;
          bank    <= ~bank;
        end else begin
          col <= col + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_first   <= (col == '0);
    p1_gen     <= gen;
    p1_gen_one <= gen_val;
    p1_wbank   <= bank;
    p1_addr    <= col;
  end

  // row buffers: the row being built writes one bank, reads the other
  always_ff @(posedge clk) begin
    if (p1_valid && !p1_wbank) begin
      mem_a[p1_addr] <= w_new;
    end
    rd_a <= mem_a[col];
  end

  always_ff @(posedge clk) begin
    if (p1_valid && p1_wbank) begin
      mem_b[p1_addr] <= w_new;
    end
    rd_b <= mem_b[col];
  end

  // window stage: w + new entry - entry ten places back, reduced mod P
  always_comb begin
    if (p1_gen) begin
      d = {{(CNT_W-1){1'b0}}, p1_gen_one};
    end else if (p1_wbank) begin
      d = rd_a;
    end else begin
      d = rd_b;
    end
    w_prev = p1_first ? '0 : window;
    old    = p1_first ? '0 : sh[WINDOW_LEN-1];
    t  = {2'b00, w_prev} + {2'b00, d} - {2'b00, old};
    tp = t + {2'b00, MODULUS};
    tm = t - {2'b00, MODULUS};
    if (t[31]) begin
      w_new = tp[CNT_W-1:0];
    end else if (t >= {2'b00, MODULUS}) begin
      w_new = tm[CNT_W-1:0];
    end else begin
      w_new = t[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (p1_valid) begin
      window <= w_new;
    end
  end

  // last ten entries of the source row; cleared as a row starts
  always_ff @(posedge clk) begin
    if (p1_valid) begin
      sh[0] <= d;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        sh[i] <= p1_first ? '0 : sh[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (cmd.sel)
        RES_ZERO:    count <= '0;
        RES_ONE_ROW: count <= {{(CNT_W-1){1'b0}},
                               (s_q != '0) && (s_q <= S_W'(DIGIT_MAX))};
        RES_WINDOW:  count <= window;
        default:     count <= '0;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/digit_sum_count_mod.sv */
// Counts the n-digit decimal numbers (no leading zero) whose digit sum is s,
// modulo 1000000007. One query is worked at a time: the digit-DP rows are
// rebuilt in two ping-pong row buffers, one entry per cycle, only up to column
// s. Each row buffer has a single read port, and the window stage makes one
// update per cycle. Queries with n = 0, n above MAX_DIGITS, s = 0,
// s >= SUM_LIMIT or s > 9n, and single-digit queries, need no row work: the
// controller goes from CHECK straight to DONE. The next query is taken
// while a finished result still waits in the output register.
// Depends on dscm_pkg, dscm_ctrl and dscm_datapath.
`default_nettype none

module digit_sum_count_mod
  import dscm_pkg::*;
#(
  parameter int MAX_DIGITS = 100,
  parameter int SUM_LIMIT  = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [N_W-1:0]   num_digits,
  input  logic [S_W-1:0]   target_sum,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CNT_W-1:0] count
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  dscm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  dscm_datapath #(
    .MAX_DIGITS (MAX_DIGITS),
    .SUM_LIMIT  (SUM_LIMIT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .num_digits (num_digits),
    .target_sum (target_sum),
    .count      (count)
  );

  // output register is only loaded when free or being drained
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken item");

  // busy once a query is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after accept");

  a_count_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count < MODULUS))
    else $error("count not reduced");

  a_no_issue_when_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!cmd.issue && !cmd.row_init))
    else $error("row work while idle");

endmodule

`default_nettype wire
